>>> design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define KST_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kst check failed");

// next-cycle implication, clocked on clk, off while arst_n is low
`define KST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kst check failed");

`endif

>>> design/kst_pkg.sv
// types, scan code constants and key tables of the scan code translator
package kst_pkg;

	// item opcodes
	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_SYNC = 1'b1;

	// scan codes
	localparam logic [7:0] SC_BKSP       = 8'h0E;
	localparam logic [7:0] SC_ENTER      = 8'h1C;
	localparam logic [7:0] SC_LSHIFT     = 8'h2A;
	localparam logic [7:0] SC_RSHIFT     = 8'h36;
	localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
	localparam logic [7:0] SC_CAPS       = 8'h3A;
	localparam logic [7:0] SC_NUM        = 8'h45;
	localparam logic [7:0] SC_SCROLL     = 8'h46;
	localparam logic [7:0] KB_ACK        = 8'hFA;
	localparam logic [7:0] KB_RESEND     = 8'hFE;

	// bytes and characters
	localparam logic [7:0] CMD_LED    = 8'hED;
	localparam logic [7:0] CH_BS      = 8'h08;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_BIT   = 8'h20;

	// led bits
	localparam int LED_CAPS   = 2;
	localparam int LED_NUM    = 1;
	localparam int LED_SCROLL = 0;

	// what the back end has to do for an item
	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_LEDS,
		ACT_ACK,
		ACT_RESEND
	} kst_act_t;

	// front to back
	typedef struct packed {
		logic [7:0] char_code;
		logic [2:0] led_state;
		kst_act_t   act;
	} kst_mid_t;

	// one result
	typedef struct packed {
		logic       char_valid;
		logic [7:0] char_code;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic [2:0] led_state;
		logic       queue_dropped;
	} kst_res_t;

	// one led command in the queue: 0xED, then the led byte if it made it in
	typedef struct packed {
		logic       has_second;
		logic [2:0] leds;
	} kst_entry_t;

	localparam logic [7:0] PLAIN_TABLE [128] = '{
		8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h5E, 8'h00, 8'h00,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4F, 8'h50, 8'h40, 8'h5B, 8'h00, 8'h00, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3B,
		8'h3A, 8'h00, 8'h00, 8'h5D, 8'h5A, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4E, 8'h4D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
		8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
		8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
		8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00
	};

	localparam logic [7:0] SHIFTED_TABLE [128] = '{
		8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
		8'h27, 8'h28, 8'h29, 8'h7E, 8'h3D, 8'h7E, 8'h00, 8'h00,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4F, 8'h50, 8'h60, 8'h7B, 8'h00, 8'h00, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h2B,
		8'h2A, 8'h00, 8'h00, 8'h7D, 8'h5A, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
		8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
		8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
		8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7C, 8'h00, 8'h00
	};

endpackage

>>> design/kst_ram.sv
// generic single-port-write ram with registered read
module kst_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/kst_fifo.sv
// small register fifo used between the stages and at the result side
module kst_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> design/kst_front.sv
// front end: key translation, shift and lock tracking, item classification
module kst_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_data,
	input  logic              item_valid,
	input  logic              op,
	input  logic [7:0]        scan_code,
	output kst_pkg::kst_mid_t mid
);

	logic [2:0] initial_leds_q;
	logic [1:0] shift_q;
	logic [2:0] leds_q;
	logic [1:0] shift_d;
	logic [2:0] leds_d;
	logic       shifted;
	logic [7:0] lut;
	logic [7:0] ch;
	kst_pkg::kst_act_t act;

	assign shifted = |shift_q;
	assign lut = shifted ? kst_pkg::SHIFTED_TABLE[scan_code[6:0]]
	                     : kst_pkg::PLAIN_TABLE[scan_code[6:0]];

	always_comb begin
		ch      = '0;
		shift_d = shift_q;
		leds_d  = leds_q;
		act     = kst_pkg::ACT_NONE;
		if (op == kst_pkg::OP_SYNC) begin
			leds_d = initial_leds_q;
			act    = kst_pkg::ACT_LEDS;
		end else begin
			if (!scan_code[7]) begin
				ch = lut;
				// letters: lower case unless exactly one of caps and shift
				if ((lut inside {[kst_pkg::CH_UPPER_A:kst_pkg::CH_UPPER_Z]}) &&
				    (leds_q[kst_pkg::LED_CAPS] == shifted)) begin
					ch = lut | kst_pkg::CASE_BIT;
				end
			end
			case (scan_code)
				kst_pkg::SC_BKSP:       ch = kst_pkg::CH_BS;
				kst_pkg::SC_ENTER:      ch = kst_pkg::CH_LF;
				kst_pkg::SC_LSHIFT:     shift_d[0] = 1'b1;
				kst_pkg::SC_RSHIFT:     shift_d[1] = 1'b1;
				kst_pkg::SC_LSHIFT_BRK: shift_d[0] = 1'b0;
				kst_pkg::SC_RSHIFT_BRK: shift_d[1] = 1'b0;
				kst_pkg::SC_CAPS: begin
					leds_d[kst_pkg::LED_CAPS] = ~leds_q[kst_pkg::LED_CAPS];
					act = kst_pkg::ACT_LEDS;
				end
				kst_pkg::SC_NUM: begin
					leds_d[kst_pkg::LED_NUM] = ~leds_q[kst_pkg::LED_NUM];
					act = kst_pkg::ACT_LEDS;
				end
				kst_pkg::SC_SCROLL: begin
					leds_d[kst_pkg::LED_SCROLL] = ~leds_q[kst_pkg::LED_SCROLL];
					act = kst_pkg::ACT_LEDS;
				end
				kst_pkg::KB_ACK:        act = kst_pkg::ACT_ACK;
				kst_pkg::KB_RESEND:     act = kst_pkg::ACT_RESEND;
				default: ;
			endcase
		end
	end

	assign mid.char_code = ch;
	assign mid.led_state = leds_d;
	assign mid.act       = act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_leds_q <= '0;
			shift_q        <= '0;
			leds_q         <= '0;
		end else begin
			if (cfg_we) begin
				initial_leds_q <= cfg_data;
			end
			if (item_valid) begin
				shift_q <= shift_d;
				leds_q  <= leds_d;
			end
		end
	end

endmodule

>>> design/kst_back.sv
// back end: led command queue, ack and resend handling, transmit selection
module kst_back #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mid_valid,
	input  kst_pkg::kst_mid_t mid,
	output logic              mid_pop,
	input  logic              res_ready,
	output logic              res_push,
	output kst_pkg::kst_res_t res
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW-1:0] LAST    = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_C  = CW'(QUEUE_DEPTH);
	localparam logic [CW:0]   LIMIT_X = (CW + 1)'(QUEUE_DEPTH);
	localparam int EW = $bits(kst_pkg::kst_entry_t);

	// queue state, counted in bytes
	logic [CW-1:0] count_q;
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic          phase_q;
	logic          pending_q;
	logic [7:0]    pending_byte_q;
	logic          byp_q;
	kst_pkg::kst_entry_t byp_data_q;

	logic          go;
	logic          we;
	kst_pkg::kst_entry_t new_entry;
	kst_pkg::kst_entry_t head;
	logic [EW-1:0] ram_rdata;
	logic [CW:0]   sum2;
	logic [CW-1:0] count_a;
	logic [CW-1:0] count_d;
	logic [AW-1:0] wr_d;
	logic [AW-1:0] rd_d;
	logic          phase_d;
	logic          pend_a;
	logic          pending_d;
	logic [7:0]    pending_byte_d;
	logic          tx_valid;
	logic [7:0]    tx_byte;
	logic          dropped;
	logic          deq;
	logic [7:0]    deq_byte;

	assign go       = mid_valid && res_ready;
	assign mid_pop  = go;
	assign res_push = go;

	assign sum2 = {1'b0, count_q} + (CW + 1)'(2);

	// head entry: fresh write when the queue is empty, else the prefetched one
	assign head = (count_q == '0) ? new_entry
	                              : (byp_q ? byp_data_q : kst_pkg::kst_entry_t'(ram_rdata));

	always_comb begin
		we                   = 1'b0;
		new_entry.leds       = mid.led_state;
		new_entry.has_second = 1'b1;
		count_a              = count_q;
		dropped              = 1'b0;
		pend_a               = pending_q;
		tx_valid             = 1'b0;
		tx_byte              = '0;
		case (mid.act)
			kst_pkg::ACT_LEDS: begin
				if (sum2 <= LIMIT_X) begin
					we      = go;
					count_a = sum2[CW-1:0];
				end else if (count_q != FULL_C) begin
					// only the command byte fits
					we                   = go;
					new_entry.has_second = 1'b0;
					count_a              = count_q + 1'b1;
					dropped              = 1'b1;
				end else begin
					dropped = 1'b1;
				end
			end
			kst_pkg::ACT_ACK: pend_a = 1'b0;
			kst_pkg::ACT_RESEND: begin
				if (pending_q) begin
					tx_valid = 1'b1;
					tx_byte  = pending_byte_q;
				end
			end
			default: ;
		endcase

		deq            = !pend_a && (count_a != '0);
		deq_byte       = phase_q ? {5'b0, head.leds} : kst_pkg::CMD_LED;
		count_d        = count_a;
		pending_d      = pend_a;
		pending_byte_d = pending_byte_q;
		phase_d        = phase_q;
		rd_d           = rd_q;
		if (deq) begin
			count_d        = count_a - 1'b1;
			pending_d      = 1'b1;
			pending_byte_d = deq_byte;
			tx_valid       = 1'b1;
			tx_byte        = deq_byte;
			if (!phase_q && head.has_second) begin
				phase_d = 1'b1;
			end else begin
				phase_d = 1'b0;
				rd_d    = (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
		end
		if (!go) begin
			rd_d = rd_q;
		end
		wr_d = we ? ((wr_q == LAST) ? '0 : wr_q + 1'b1) : wr_q;
	end

	kst_ram #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (wr_q),
		.wdata (new_entry),
		.raddr (rd_d),
		.rdata (ram_rdata)
	);

	assign res.char_valid    = (mid.char_code != '0);
	assign res.char_code     = mid.char_code;
	assign res.tx_valid      = tx_valid;
	assign res.tx_byte       = tx_byte;
	assign res.led_state     = mid.led_state;
	assign res.queue_dropped = dropped;

	always_ff @(posedge clk) begin
		byp_data_q <= new_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			wr_q           <= '0;
			rd_q           <= '0;
			phase_q        <= 1'b0;
			pending_q      <= 1'b0;
			pending_byte_q <= '0;
			byp_q          <= 1'b0;
		end else begin
			// ram read is read-first, so a same-address write is forwarded
			byp_q <= we && (wr_q == rd_d);
			if (go) begin
				count_q        <= count_d;
				wr_q           <= wr_d;
				rd_q           <= rd_d;
				phase_q        <= phase_d;
				pending_q      <= pending_d;
				pending_byte_q <= pending_byte_d;
			end
		end
	end

endmodule

>>> design/keyboard_scancode_translator_unit.sv
// top level of the set 1 scan code to ascii translator
//
// input channel: push/full carries op and scan_code; a transfer happens at a
// clock edge with push high and full low. op 0 hands in a keyboard byte, op 1
// loads the leds from the config register and queues the led command.
// result channel: empty/pop; the oldest result sits on the result ports while
// empty is low and leaves at an edge with pop high. every item gives exactly
// one result, in order.
// config channel: cfg_valid/cfg_ready, always ready, writes the 3-bit initial
// led value; the user must see it is only written while the block is idle;
// the block itself does not enforce this. a result passes the stage queue, the
// back end and the output queue before it is on the result ports. throughput is
// one item per cycle while the receiver keeps up, set by the command queue
// update in the back end (one entry write and one prefetched read per cycle).
// the front end and back end are parted by a two-entry queue, and results go
// through a two-entry output queue, so a stalled receiver first fills those
// and then raises full; nothing is lost.
// reset clears shift, led, queue and pending-ack state; the command queue ram
// itself needs no clearing since only written entries are ever read.
module keyboard_scancode_translator_unit #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	// config
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_data,
	// input items
	input  logic       push,
	output logic       full,
	input  logic       op,
	input  logic [7:0] scan_code,
	// results
	output logic       empty,
	input  logic       pop,
	output logic       char_valid,
	output logic [7:0] char_code,
	output logic       tx_valid,
	output logic [7:0] tx_byte,
	output logic [2:0] led_state,
	output logic       queue_dropped
);

	localparam int STAGE_DEPTH = 2;

	kst_pkg::kst_mid_t mid_in;
	kst_pkg::kst_mid_t mid_out;
	kst_pkg::kst_res_t res_in;
	kst_pkg::kst_res_t res_out;
	logic              mid_full;
	logic              mid_empty;
	logic              mid_pop;
	logic              res_full;
	logic              res_push;
	logic              in_xfer;

	// config register always takes the write
	assign cfg_ready = 1'b1;
	assign full      = mid_full;
	assign in_xfer   = push && !mid_full;

	// front end: translate and classify
	kst_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid),
		.cfg_data   (cfg_data),
		.item_valid (in_xfer),
		.op         (op),
		.scan_code  (scan_code),
		.mid        (mid_in)
	);

	// queue between front and back
	kst_fifo #(
		.WIDTH ($bits(kst_pkg::kst_mid_t)),
		.DEPTH (STAGE_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_xfer),
		.wdata  (mid_in),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_out),
		.empty  (mid_empty)
	);

	// back end: command queue and keyboard transmit
	kst_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_valid (!mid_empty),
		.mid       (mid_out),
		.mid_pop   (mid_pop),
		.res_ready (!res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// result queue, decouples the receiver from the back end
	kst_fifo #(
		.WIDTH ($bits(kst_pkg::kst_res_t)),
		.DEPTH (STAGE_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign char_valid    = res_out.char_valid;
	assign char_code     = res_out.char_code;
	assign tx_valid      = res_out.tx_valid;
	assign tx_byte       = res_out.tx_byte;
	assign led_state     = res_out.led_state;
	assign queue_dropped = res_out.queue_dropped;

endmodule

>>> design/kst_checker.sv
// port-level checks of the translator and their binding
`include "assert_macros.svh"

module kst_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic       char_valid,
	input logic [7:0] char_code,
	input logic       tx_valid,
	input logic [7:0] tx_byte
);

	// a result waiting while the receiver stalls does not change
	`KST_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(char_code) && $stable(tx_byte))

	// char_valid follows a nonzero character
	`KST_ASSERT_SAME(a_char_flag, !empty, char_valid == (char_code != 8'h00))

	// no byte shown when nothing goes to the keyboard
	`KST_ASSERT_SAME(a_tx_zero, !empty && !tx_valid, tx_byte == 8'h00)

	// an accepted item has a result showing once through the stage and output queues
	`KST_ASSERT_SAME(a_latency, $past(push && !full && arst_n, 2) && $past(arst_n), !empty)

endmodule

bind keyboard_scancode_translator_unit kst_checker u_kst_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.push       (push),
	.full       (full),
	.empty      (empty),
	.pop        (pop),
	.char_valid (char_valid),
	.char_code  (char_code),
	.tx_valid   (tx_valid),
	.tx_byte    (tx_byte)
);
